// File: src/bpfm_pkg.sv
// shared types and constants for the buffer pool frame manager
package bpfm_pkg;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VICTIM,
    ST_SCAN,
    ST_EMIT,
    ST_MOVE,
    ST_DONE
  } state_t;

  // one frame as seen by the scan unit
  typedef struct packed {
    logic [3:0] table_tag;
    logic       dirty;
    logic       pinned;
  } frame_view_t;

endpackage

// File: src/bpfm_recency.sv
// recency list of frame slots, oldest at position zero, one move per cycle
module bpfm_recency #(
  parameter int NUM_FRAMES = 16,
  parameter int SLOT_BITS  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SLOT_BITS-1:0] rd_pos,
  output logic [SLOT_BITS-1:0] rd_slot,
  input  logic                 move,
  input  logic [SLOT_BITS-1:0] move_slot
);

  logic [SLOT_BITS-1:0] order [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] match;
  logic [NUM_FRAMES-1:0] shift;

  assign rd_slot = order[rd_pos];

  // positions at and after the moved slot shift down one place
  always_comb begin
    for (int p = 0; p < NUM_FRAMES; p++) begin
      match[p] = (order[p] == move_slot);
    end
    shift[0] = match[0];
    for (int p = 1; p < NUM_FRAMES; p++) begin
      shift[p] = shift[p-1] | match[p];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_FRAMES; p++) begin
        order[p] <= SLOT_BITS'(p);
      end
    end else if (move && shift[NUM_FRAMES-1]) begin
      for (int p = 0; p < NUM_FRAMES - 1; p++) begin
        if (shift[p]) begin
          order[p] <= order[p+1];
        end
      end
      order[NUM_FRAMES-1] <= move_slot;
    end
  end

endmodule

// File: src/buffer_pool_frame_manager.sv
// buffer pool frame manager top level: sequencer, frame store and scan unit
// Each item is handled by a sequencer that walks the frames one per cycle
// with a single shared compare unit, and the block takes no new item until
// the last result of the current one has been taken. A read or write walks
// the participating slots for a lookup; a hit passes through the move
// state, which registers its result. A miss walks all participating slots,
// then the recency list for the victim, one position per cycle in up to four
// passes over the list, and the move state then registers its result. An
// ignored item is rejected in the lookup state, which registers its result.
// A close first counts the matching frames over the participating slots;
// close and flush then walk the recency list, one position per cycle while
// no result is waiting to be taken, and each result is held until taken.
// Every frame is cleared by reset, so no clearing pass is needed.
module buffer_pool_frame_manager #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 32,
  parameter int MAX_TABLES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [4:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  table_tag,
  input  logic [31:0] page_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ignored,
  output logic        hit,
  output logic [3:0]  frame_slot,
  output logic        fetch_needed,
  output logic        victim_valid,
  output logic [3:0]  victim_table,
  output logic [31:0] victim_page,
  output logic        victim_dirty,
  output logic        last
);

  localparam int SLOT_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_BITS  = $clog2(NUM_FRAMES + 1);
  localparam int PW = (PAGE_BITS < 32) ? PAGE_BITS : 32;

  // configuration
  logic [4:0]           frames_in_use;
  logic [CNT_BITS-1:0]  active;

  // frame store
  logic [3:0]            f_table  [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  f_page   [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] f_dirty;
  logic [NUM_FRAMES-1:0] f_pinned;

  // latched item
  logic [1:0]           op_r;
  logic [3:0]           tag_r;
  logic [PAGE_BITS-1:0] page_r;

  bpfm_pkg::state_t state, state_next;
  logic [SLOT_BITS-1:0] idx;        // slot or recency position
  logic [1:0]           pass;
  logic [SLOT_BITS-1:0] sel_slot;
  logic                 hit_r;
  logic [CNT_BITS-1:0]  remaining;  // matches counted, then results still to give

  // recency list
  logic [SLOT_BITS-1:0] rec_slot;
  logic                 rec_move;

  // compare unit
  logic [SLOT_BITS-1:0]  cmp_slot;
  bpfm_pkg::frame_view_t fv;
  logic cmp_in, cmp_hit, cmp_victim, cmp_tag;
  logic idx_end, lookup_end;

  // item checks and handshakes
  logic                tag_ok;
  logic                bad_item;
  logic                scan_match;
  logic [CNT_BITS-1:0] close_total;
  logic                accept_in, accept_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 5'd16;
    end else if (cfg_write_enable) begin
      frames_in_use <= cfg_write_data;
    end
  end

  always_comb begin
    if (frames_in_use == 5'd0) begin
      active = CNT_BITS'(1);
    end else if (32'(frames_in_use) > NUM_FRAMES) begin
      active = CNT_BITS'(NUM_FRAMES);
    end else begin
      active = CNT_BITS'(frames_in_use);
    end
  end

  bpfm_recency #(.NUM_FRAMES(NUM_FRAMES), .SLOT_BITS(SLOT_BITS)) u_rec (
    .clk(clk), .rst(rst), .rd_pos(idx), .rd_slot(rec_slot),
    .move(rec_move), .move_slot(sel_slot)
  );

  // shared compare unit: examines one slot
  always_comb begin
    cmp_slot = (state == bpfm_pkg::ST_LOOKUP) ? idx : rec_slot;
    fv.table_tag = f_table[cmp_slot];
    fv.dirty     = f_dirty[cmp_slot];
    fv.pinned    = f_pinned[cmp_slot];
    cmp_in  = (CNT_BITS'(cmp_slot) < active);
    cmp_tag = (fv.table_tag == tag_r);
    cmp_hit = cmp_in && cmp_tag && (f_page[cmp_slot] == page_r);
    unique case (pass)
      2'd0: cmp_victim = cmp_in && (fv.table_tag == 4'd0);
      2'd1: cmp_victim = cmp_in && !fv.dirty && !fv.pinned;
      2'd2: cmp_victim = cmp_in && !fv.pinned;
      default: cmp_victim = cmp_in;
    endcase
    idx_end    = (32'(idx) == NUM_FRAMES - 1);
    lookup_end = ((CNT_BITS'(idx) + CNT_BITS'(1)) == active);
  end

  // item checks
  always_comb begin
    tag_ok      = (tag_r != 4'd0) && (32'(tag_r) <= MAX_TABLES);
    bad_item    = !tag_ok || (op_r != bpfm_pkg::OP_CLOSE && page_r == '0);
    scan_match  = (op_r == bpfm_pkg::OP_FLUSH) ? cmp_in : (cmp_in && cmp_tag);
    close_total = remaining + CNT_BITS'(cmp_in && cmp_tag);
  end

  // handshakes and recency moves
  always_comb begin
    in_stall   = (state != bpfm_pkg::ST_IDLE);
    accept_in  = in_valid && !in_stall;
    accept_out = out_valid && !out_stall;
    rec_move   = (state == bpfm_pkg::ST_MOVE) ||
                 (state == bpfm_pkg::ST_EMIT && accept_out &&
                  op_r == bpfm_pkg::OP_CLOSE);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpfm_pkg::ST_IDLE: begin
        if (accept_in) begin
          state_next = bpfm_pkg::ST_LOOKUP;
        end
      end
      bpfm_pkg::ST_LOOKUP: begin
        if (op_r == bpfm_pkg::OP_FLUSH) begin
          state_next = bpfm_pkg::ST_SCAN;
        end else if (bad_item) begin
          state_next = bpfm_pkg::ST_DONE;
        end else if (op_r == bpfm_pkg::OP_CLOSE) begin
          if (lookup_end) begin
            state_next = (close_total == '0) ? bpfm_pkg::ST_DONE : bpfm_pkg::ST_SCAN;
          end
        end else if (cmp_hit) begin
          state_next = bpfm_pkg::ST_MOVE;
        end else if (lookup_end) begin
          state_next = bpfm_pkg::ST_VICTIM;
        end
      end
      bpfm_pkg::ST_VICTIM: begin
        if (cmp_victim) begin
          state_next = bpfm_pkg::ST_MOVE;
        end
      end
      bpfm_pkg::ST_SCAN: begin
        if (scan_match) begin
          state_next = bpfm_pkg::ST_EMIT;
        end
      end
      bpfm_pkg::ST_EMIT: begin
        if (accept_out) begin
          state_next = last ? bpfm_pkg::ST_IDLE : bpfm_pkg::ST_SCAN;
        end
      end
      bpfm_pkg::ST_MOVE: begin
        state_next = bpfm_pkg::ST_DONE;
      end
      bpfm_pkg::ST_DONE: begin
        if (accept_out) begin
          state_next = bpfm_pkg::ST_IDLE;
        end
      end
      default: state_next = bpfm_pkg::ST_IDLE;
    endcase
  end

  // sequencer registers, frame store and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpfm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      op_r      <= '0;
      tag_r     <= '0;
      page_r    <= '0;
      idx       <= '0;
      pass      <= '0;
      sel_slot  <= '0;
      hit_r     <= 1'b0;
      remaining <= '0;
      {ignored, hit, frame_slot, fetch_needed} <= '0;
      {victim_valid, victim_table, victim_page, victim_dirty} <= '0;
      last      <= 1'b0;
      for (int s = 0; s < NUM_FRAMES; s++) begin
        f_table[s] <= '0;
        f_page[s]  <= '0;
      end
      f_dirty   <= '0;
      f_pinned  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        bpfm_pkg::ST_IDLE: begin
          if (accept_in) begin
            op_r      <= operation;
            tag_r     <= table_tag;
            page_r    <= PAGE_BITS'(page_number);
            idx       <= '0;
            pass      <= '0;
            hit_r     <= 1'b0;
            remaining <= '0;
          end
        end
        bpfm_pkg::ST_LOOKUP: begin
          if (op_r == bpfm_pkg::OP_FLUSH) begin
            idx       <= '0;
            remaining <= active;
          end else if (bad_item) begin
            {ignored, hit, frame_slot, fetch_needed} <= {1'b1, 1'b0, 4'd0, 1'b0};
            {victim_valid, victim_table, victim_page, victim_dirty} <= '0;
            last      <= 1'b1;
            out_valid <= 1'b1;
          end else if (op_r == bpfm_pkg::OP_CLOSE) begin
            // count the frames of the table before giving any result
            remaining <= close_total;
            if (lookup_end) begin
              idx <= '0;
              if (close_total == '0) begin
                {ignored, hit, frame_slot, fetch_needed} <= '0;
                {victim_valid, victim_table, victim_page, victim_dirty} <= '0;
                last      <= 1'b1;
                out_valid <= 1'b1;
              end
            end else begin
              idx <= idx + SLOT_BITS'(1);
            end
          end else if (cmp_hit) begin
            sel_slot <= idx;
            hit_r    <= 1'b1;
          end else if (lookup_end) begin
            idx <= '0;
          end else begin
            idx <= idx + SLOT_BITS'(1);
          end
        end
        bpfm_pkg::ST_VICTIM: begin
          if (cmp_victim) begin
            sel_slot <= rec_slot;
          end else if (idx_end) begin
            idx  <= '0;
            pass <= pass + 2'd1;
          end else begin
            idx <= idx + SLOT_BITS'(1);
          end
        end
        bpfm_pkg::ST_SCAN: begin
          if (scan_match) begin
            {ignored, hit, frame_slot, fetch_needed} <= {1'b0, 1'b0, 4'(rec_slot), 1'b0};
            victim_valid <= (f_table[rec_slot] != 4'd0);
            victim_table <= f_table[rec_slot];
            victim_page  <= 32'(f_page[rec_slot][PW-1:0]);
            victim_dirty <= f_dirty[rec_slot];
            last         <= (remaining == CNT_BITS'(1));
            out_valid    <= 1'b1;
            remaining    <= remaining - CNT_BITS'(1);
            sel_slot     <= rec_slot;
            // a closed frame leaves its position, so the next one moves in
            if (op_r == bpfm_pkg::OP_FLUSH) begin
              idx <= idx_end ? '0 : idx + SLOT_BITS'(1);
            end
          end else begin
            idx <= idx_end ? '0 : idx + SLOT_BITS'(1);
          end
        end
        bpfm_pkg::ST_EMIT: begin
          if (accept_out) begin
            out_valid <= 1'b0;
            if (op_r == bpfm_pkg::OP_CLOSE) begin
              f_table[sel_slot]  <= '0;
              f_page[sel_slot]   <= '0;
              f_dirty[sel_slot]  <= 1'b0;
              f_pinned[sel_slot] <= 1'b0;
            end
          end
        end
        bpfm_pkg::ST_MOVE: begin
          ignored      <= 1'b0;
          hit          <= hit_r;
          frame_slot   <= 4'(sel_slot);
          last         <= 1'b1;
          out_valid    <= 1'b1;
          fetch_needed <= !hit_r && (op_r == bpfm_pkg::OP_READ);
          if (hit_r || f_table[sel_slot] == 4'd0) begin
            {victim_valid, victim_table, victim_page, victim_dirty} <= '0;
          end else begin
            victim_valid <= 1'b1;
            victim_table <= f_table[sel_slot];
            victim_page  <= 32'(f_page[sel_slot][PW-1:0]);
            victim_dirty <= f_dirty[sel_slot];
          end
          if (!hit_r) begin
            f_table[sel_slot]  <= tag_r;
            f_page[sel_slot]   <= page_r;
            f_dirty[sel_slot]  <= (op_r == bpfm_pkg::OP_WRITE);
            f_pinned[sel_slot] <= (op_r == bpfm_pkg::OP_READ);
          end else if (op_r == bpfm_pkg::OP_READ) begin
            f_pinned[sel_slot] <= 1'b1;
          end else begin
            f_dirty[sel_slot]  <= 1'b1;
            f_pinned[sel_slot] <= 1'b0;
          end
        end
        bpfm_pkg::ST_DONE: begin
          if (accept_out) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // no item is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("item accepted while a result is pending");
  // a hit never reports a victim
  assert property (@(posedge clk) disable iff (rst) (out_valid && hit) |-> !victim_valid)
    else $error("hit with victim");
  // an ignored access is always a single result
  assert property (@(posedge clk) disable iff (rst) (out_valid && ignored) |-> last)
    else $error("ignored result not last");
  // a stalled result stays offered and unchanged
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(frame_slot) && $stable(last)))
    else $error("stalled result changed");

endmodule

// File: tb/buffer_pool_frame_manager_tb.sv
// self-checking testbench for the buffer pool frame manager
`timescale 1ns / 1ps

module buffer_pool_frame_manager_tb;

  localparam int NFR = 16;
  localparam int MAXTAB = 10;
  localparam int STALL_LIMIT = 20000;

  // one result of the block
  typedef struct packed {
    logic        ignored;
    logic        hit;
    logic [3:0]  frame_slot;
    logic        fetch_needed;
    logic        victim_valid;
    logic [3:0]  victim_table;
    logic [31:0] victim_page;
    logic        victim_dirty;
    logic        last;
  } pool_result_t;

  // one directed row; when has_exp is set the first result is typed in
  typedef struct {
    logic [1:0]   op;
    logic [3:0]   tag;
    logic [31:0]  page;
    bit           has_exp;
    pool_result_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic [4:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = '0;
  logic [3:0] table_tag = '0;
  logic [31:0] page_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ignored, hit, fetch_needed, victim_valid, victim_dirty, last;
  logic [3:0] frame_slot, victim_table;
  logic [31:0] victim_page;

  buffer_pool_frame_manager uut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .table_tag(table_tag), .page_number(page_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .ignored(ignored), .hit(hit), .frame_slot(frame_slot),
    .fetch_needed(fetch_needed), .victim_valid(victim_valid),
    .victim_table(victim_table), .victim_page(victim_page),
    .victim_dirty(victim_dirty), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the pool
  logic [4:0]  pool_count;
  logic [3:0]  pool_table [NFR];
  logic [31:0] pool_page [NFR];
  logic        pool_dirty [NFR];
  logic        pool_pinned [NFR];
  int          pool_order [NFR];

  pool_result_t pending_results [$];
  int error_count = 0;
  bit quiet_mode = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic pool_result_t mk(input logic ign, input logic h, input int slot,
      input logic fetch, input logic vv, input int vt, input logic [31:0] vp,
      input logic vd, input logic lst);
    pool_result_t r;
    r.ignored = ign; r.hit = h; r.frame_slot = slot[3:0]; r.fetch_needed = fetch;
    r.victim_valid = vv; r.victim_table = vt[3:0]; r.victim_page = vp;
    r.victim_dirty = vd; r.last = lst;
    return r;
  endfunction

  // append one expected result
  function automatic void expect_result(input pool_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic int frames_active();
    if (pool_count == 0) return 1;
    if (pool_count > NFR) return NFR;
    return pool_count;
  endfunction

  function automatic void move_to_newest(input int slot);
    int p;
    int q;
    for (p = 0; p < NFR; p++) begin
      if (pool_order[p] == slot) begin
        for (q = p; q < NFR - 1; q++) pool_order[q] = pool_order[q + 1];
        pool_order[NFR - 1] = slot;
        return;
      end
    end
  endfunction

  function automatic int choose_victim(input int n);
    int pass;
    int p;
    int s;
    for (pass = 0; pass < 3; pass++) begin
      for (p = 0; p < NFR; p++) begin
        s = pool_order[p];
        if (s < n) begin
          if (pass == 0 && pool_table[s] == 0) return s;
          if (pass == 1 && !pool_dirty[s] && !pool_pinned[s]) return s;
          if (pass == 2 && !pool_pinned[s]) return s;
        end
      end
    end
    for (p = 0; p < NFR; p++) if (pool_order[p] < n) return pool_order[p];
    return 0;
  endfunction

  function automatic void pool_reset();
    int i;
    pool_count = 5'd16;
    for (i = 0; i < NFR; i++) begin
      pool_table[i] = '0; pool_page[i] = '0; pool_dirty[i] = 1'b0;
      pool_pinned[i] = 1'b0; pool_order[i] = i;
    end
  endfunction

  // apply one access to the pool copy and queue its results
  function automatic void predict_access(input logic [1:0] op, input logic [3:0] tag,
      input logic [31:0] page);
    int n;
    int p;
    int s;
    int list [$];
    logic vv;
    n = frames_active();
    if (op == bpfm_pkg::OP_FLUSH) begin
      for (p = 0; p < NFR; p++) if (pool_order[p] < n) list = {list, pool_order[p]};
      foreach (list[i]) begin
        s = list[i];
        expect_result(mk(0, 0, s, 0, pool_table[s] != 0, pool_table[s],
          pool_page[s], pool_dirty[s], i == list.size() - 1));
      end
      return;
    end
    if (tag == 0 || tag > MAXTAB || (op != bpfm_pkg::OP_CLOSE && page == 0)) begin
      expect_result(mk(1, 0, 0, 0, 0, 0, 0, 0, 1));
      return;
    end
    if (op == bpfm_pkg::OP_CLOSE) begin
      for (p = 0; p < NFR; p++)
        if (pool_order[p] < n && pool_table[pool_order[p]] == tag)
          list = {list, pool_order[p]};
      if (list.size() == 0) expect_result(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
      foreach (list[i]) begin
        s = list[i];
        expect_result(mk(0, 0, s, 0, 1, pool_table[s], pool_page[s],
          pool_dirty[s], i == list.size() - 1));
        pool_table[s] = '0; pool_page[s] = '0; pool_dirty[s] = 0; pool_pinned[s] = 0;
        move_to_newest(s);
      end
      return;
    end
    for (s = 0; s < n; s++) begin
      if (pool_table[s] == tag && pool_page[s] == page) begin
        if (op == bpfm_pkg::OP_READ) pool_pinned[s] = 1'b1;
        else begin
          pool_dirty[s] = 1'b1; pool_pinned[s] = 1'b0;
        end
        move_to_newest(s);
        expect_result(mk(0, 1, s, 0, 0, 0, 0, 0, 1));
        return;
      end
    end
    s = choose_victim(n);
    vv = pool_table[s] != 0;
    expect_result(mk(0, 0, s, op == bpfm_pkg::OP_READ, vv, vv ? pool_table[s] : 0,
      vv ? pool_page[s] : 0, vv ? pool_dirty[s] : 0, 1));
    pool_table[s] = tag; pool_page[s] = page;
    pool_dirty[s] = op == bpfm_pkg::OP_WRITE; pool_pinned[s] = op == bpfm_pkg::OP_READ;
    move_to_newest(s);
  endfunction

  // result side: checking
  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {ignored, hit, frame_slot, fetch_needed, victim_valid, victim_table,
             victim_page, victim_dirty, last};
      if (pending_results.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = pending_results.pop_front();
        if (got.ignored !== want.ignored) report_mismatch("ignored");
        if (got.hit !== want.hit) report_mismatch("hit");
        if (got.frame_slot !== want.frame_slot) report_mismatch("frame_slot");
        if (got.fetch_needed !== want.fetch_needed) report_mismatch("fetch_needed");
        if (got.victim_valid !== want.victim_valid) report_mismatch("victim_valid");
        if (got.victim_table !== want.victim_table) report_mismatch("victim_table");
        if (got.victim_page !== want.victim_page) report_mismatch("victim_page");
        if (got.victim_dirty !== want.victim_dirty) report_mismatch("victim_dirty");
        if (got.last !== want.last) report_mismatch("last");
      end
    end
  end

  // receiver hold-off process
  int stall_left = 0;
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (quiet_mode) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // watchdog on cycles with no accepted item or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("buffer_pool_frame_manager_tb failed");
      $finish;
    end
  end

  // offer one item, with an optional sender gap before it
  task automatic send_access(input logic [1:0] op, input logic [3:0] tag,
      input logic [31:0] page);
    int gap;
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op; table_tag <= tag; page_number <= page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_access(op, tag, page);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [4:0] value);
    drain_results();
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    pool_count = value;
  endtask

  // random page drawn from a small working set, with rare wide and zero values
  function automatic logic [31:0] pick_page();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'h0;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  task automatic send_random();
    int r;
    logic [1:0] op;
    logic [3:0] tag;
    r = $urandom_range(0, 99);
    if (r < 45) op = bpfm_pkg::OP_READ;
    else if (r < 85) op = bpfm_pkg::OP_WRITE;
    else if (r < 95) op = bpfm_pkg::OP_CLOSE;
    else op = bpfm_pkg::OP_FLUSH;
    tag = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
    send_access(op, tag, pick_page());
  endtask

  stim_row_t directed_rows [$];

  initial begin
    stim_row_t row;
    logic [4:0] phase_counts [5];
    pool_reset();
    phase_counts = '{5'd16, 5'd4, 5'd1, 5'd9, 5'd16};
    // directed table: after reset, extremes, special cases
    directed_rows = '{
      '{bpfm_pkg::OP_READ,  4'd1,  32'd0,         1, mk(1,0,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_READ,  4'd0,  32'd5,         1, mk(1,0,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_WRITE, 4'd15, 32'd5,         1, mk(1,0,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_CLOSE, 4'd11, 32'd0,         1, mk(1,0,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_CLOSE, 4'd3,  32'd0,         1, mk(0,0,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_READ,  4'd1,  32'hFFFF_FFFF, 1, mk(0,0,0,1,0,0,0,0,1)},
      '{bpfm_pkg::OP_WRITE, 4'd10, 32'd1,         1, mk(0,0,1,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_READ,  4'd1,  32'hFFFF_FFFF, 1, mk(0,1,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_WRITE, 4'd1,  32'hFFFF_FFFF, 1, mk(0,1,0,0,0,0,0,0,1)},
      '{bpfm_pkg::OP_READ,  4'd2,  32'hFFFF_FFFF, 0, mk(0,0,0,0,0,0,0,0,0)},
      '{bpfm_pkg::OP_READ,  4'd10, 32'd1,         0, mk(0,0,0,0,0,0,0,0,0)},
      '{bpfm_pkg::OP_FLUSH, 4'd0,  32'd0,         0, mk(0,0,0,0,0,0,0,0,0)},
      '{bpfm_pkg::OP_CLOSE, 4'd1,  32'd0,         0, mk(0,0,0,0,0,0,0,0,0)},
      '{bpfm_pkg::OP_WRITE, 4'd5,  32'h8000_0000, 0, mk(0,0,0,0,0,0,0,0,0)},
      '{bpfm_pkg::OP_READ,  4'd5,  32'h7FFF_FFFF, 0, mk(0,0,0,0,0,0,0,0,0)}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_access(row.op, row.tag, row.page);
      // typed rows give a single result, the newest one queued
      if (row.has_exp && pending_results[pending_results.size() - 1] !== row.exp)
        report_mismatch($sformatf("directed row %0d prediction", i));
    end
    // replacement classes with a full pool of two frames, then frame counts 1, 0 and 31
    write_frame_count(5'd2);
    send_access(bpfm_pkg::OP_READ, 4'd7, 32'd100);
    send_access(bpfm_pkg::OP_READ, 4'd7, 32'd101);
    send_access(bpfm_pkg::OP_READ, 4'd7, 32'd102);
    send_access(bpfm_pkg::OP_WRITE, 4'd8, 32'd103);
    send_access(bpfm_pkg::OP_FLUSH, 4'd0, 32'd0);
    write_frame_count(5'd1);
    send_access(bpfm_pkg::OP_WRITE, 4'd9, 32'd3);
    send_access(bpfm_pkg::OP_FLUSH, 4'd9, 32'd0);
    write_frame_count(5'd0);
    send_access(bpfm_pkg::OP_READ, 4'd9, 32'd4);
    write_frame_count(5'd31);
    send_access(bpfm_pkg::OP_FLUSH, 4'd0, 32'd0);

    // random phases over several frame counts
    foreach (phase_counts[k]) begin
      write_frame_count(phase_counts[k]);
      repeat (80) send_random();
      if (k == 1) begin
        // receiver holds off while items keep coming
        long_hold = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            long_hold = 1'b0;
          end
          repeat (6) send_random();
        join
        // sender waits for every result
        drain_results();
      end
    end
    // last stretch with no idling
    quiet_mode = 1'b1;
    repeat (40) send_random();
    drain_results();
    if (error_count == 0) $display("buffer_pool_frame_manager_tb passed");
    else $display("buffer_pool_frame_manager_tb failed");
    $finish;
  end

endmodule
